// ===== hdl/mbr_pkg.sv =====
// shared types, codes and crc function for the modbus rtu slave frame engine
`timescale 1ns / 1ps
`default_nettype none
package mbr_pkg;

    localparam int MEM_WORDS_DEF = 256;
    localparam int RX_WORDS      = 128;
    localparam int RX_AW         = 7;

    localparam logic [7:0]  FN_READ   = 8'h04;
    localparam logic [7:0]  FN_WRITE1 = 8'h06;
    localparam logic [7:0]  FN_WRITEN = 8'h10;
    localparam logic [15:0] MAX_READ  = 16'd127;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    typedef enum logic [1:0] {
        CMD_RX  = 2'd0,
        CMD_ADV = 2'd1,
        CMD_HWR = 2'd2,
        CMD_HRD = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        PH_STATION, PH_FUNC, PH_ADDR_HI, PH_ADDR_LO, PH_QTY_HI, PH_QTY_LO,
        PH_COUNT, PH_DATA_HI, PH_DATA_LO, PH_CRC_A, PH_CRC_B
    } t_phase;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         rx_byte;
        logic [15:0]        host_addr;
        logic signed [15:0] host_value;
    } t_in_item;

    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic               tx_last;
        logic               write_valid;
        logic [15:0]        write_addr;
        logic [15:0]        write_value;
        logic signed [15:0] read_value;
        logic               frame_received;
        logic               transmitting;
    } t_out_item;

    // one byte through the reflected crc-16
    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/mbr_in_if.sv =====
// input item channel
`timescale 1ns / 1ps
`default_nettype none
interface mbr_in_if;
    logic              valid;
    logic              ready;
    mbr_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/mbr_out_if.sv =====
// result item channel
`timescale 1ns / 1ps
`default_nettype none
interface mbr_out_if;
    logic               valid;
    logic               ready;
    mbr_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/mbr_cfg_if.sv =====
// station id write channel
`timescale 1ns / 1ps
`default_nettype none
interface mbr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/modbus_rtu_slave_frame_engine_core.sv =====
// modbus rtu slave frame engine: parser, response sequencer and register memory
`timescale 1ns / 1ps
`default_nettype none
// Each item is handled in two steps: the transfer edge issues the register memory and
// receive word memory reads; once the result register is free, the item applies the
// update, writes back and loads the result register, which is held until taken while
// the next item is accepted. After reset the register memory is zeroed one word a
// cycle, so no item is accepted until the clearing pass ends; station id writes are
// taken at any time.
module modbus_rtu_slave_frame_engine_core #(
    parameter int MEM_WORDS = mbr_pkg::MEM_WORDS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mbr_in_if.sink     i_in,
    mbr_out_if.source  o_out,
    mbr_cfg_if.sink    i_cfg
);

    localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam logic [16:0] MEM_END = 17'(MEM_WORDS);
    localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_WORDS - 1);

    // memories
    logic [15:0] r_reg_mem [MEM_WORDS];
    logic [15:0] r_rx_mem  [mbr_pkg::RX_WORDS];
    logic [15:0] r_mem_q;
    logic [15:0] r_rx_q;
    logic        r_oob;

    // control and state
    logic                r_clr_busy;
    logic [MEM_AW-1:0]   r_clr_addr;
    logic                r_exec;
    logic                r_out_valid;
    mbr_pkg::t_out_item  r_out;
    mbr_pkg::t_in_item   r_item;
    logic [7:0]          r_station;

    mbr_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_fc, n_fc;
    logic [15:0]     r_start, n_start;
    logic [15:0]     r_qty, n_qty;
    logic [7:0]      r_wi, n_wi;
    logic [7:0]      r_hold, n_hold;
    logic [8:0]      r_oidx, n_oidx;
    logic            r_pend, n_pend;
    mbr_pkg::t_out_item n_out;

    logic              accept;
    logic              done;
    logic [8:0]        notes;
    logic [8:0]        body;
    logic [8:0]        j_idx;
    logic [8:0]        w_idx;
    logic [16:0]       rd_addr;
    logic [mbr_pkg::RX_AW-1:0] rx_ra;

    logic                      rx_we;
    logic [mbr_pkg::RX_AW-1:0] rx_wa;
    logic [15:0]               rx_wd;
    logic                      mem_we;
    logic [MEM_AW-1:0]         mem_wa;
    logic [15:0]               mem_wd;

    // handshakes
    assign i_in.ready  = !r_exec && !r_clr_busy;
    assign accept      = i_in.valid && i_in.ready;
    assign done        = r_exec && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign i_cfg.ready = 1'b1;

    // response layout from current state
    always_comb begin
        if (r_fc == mbr_pkg::FN_WRITE1) begin
            notes = 9'd1;
        end else if (r_fc == mbr_pkg::FN_READ) begin
            notes = 9'd0;
        end else begin
            notes = r_qty[8:0];
        end
        body  = (r_fc == mbr_pkg::FN_READ) ? 9'd3 + {1'b0, r_qty[6:0], 1'b0} : 9'd6;
        j_idx = r_oidx - notes;
        w_idx = (j_idx - 9'd3) >> 1;
        if (mbr_pkg::t_cmd'(i_in.data.cmd) == mbr_pkg::CMD_HRD) begin
            rd_addr = {1'b0, i_in.data.host_addr};
        end else begin
            rd_addr = {1'b0, r_start} + {8'h00, w_idx};
        end
        rx_ra = (r_oidx < notes) ? r_oidx[mbr_pkg::RX_AW-1:0] : '0;
    end

    // register memory port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_reg_mem[mem_wa] <= mem_wd;
        end
        if (accept) begin
            r_mem_q <= r_reg_mem[rd_addr[MEM_AW-1:0]];
            r_oob   <= (rd_addr >= MEM_END);
        end
    end

    // receive word memory port
    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[rx_wa] <= rx_wd;
        end
        if (accept) begin
            r_rx_q <= r_rx_mem[rx_ra];
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in.data;
        end
        if (done) begin
            r_out <= n_out;
        end
    end

    // execute: parse, advance, host access
    always_comb begin
        logic [15:0] word;
        logic [15:0] mem_val;
        logic [15:0] v;
        logic [7:0]  b;
        logic [7:0]  bb;
        logic [8:0]  wi_inc;
        logic [16:0] avail;
        logic [15:0] q;

        n_phase = r_phase;
        n_crc   = r_crc;
        n_fc    = r_fc;
        n_start = r_start;
        n_qty   = r_qty;
        n_wi    = r_wi;
        n_hold  = r_hold;
        n_oidx  = r_oidx;
        n_pend  = r_pend;
        n_out   = '0;
        rx_we   = 1'b0;
        rx_wa   = '0;
        rx_wd   = '0;
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = '0;

        b       = r_item.rx_byte;
        word    = {r_hold, b};
        mem_val = r_oob ? 16'h0000 : r_mem_q;
        wi_inc  = {1'b0, r_wi} + 9'd1;
        v       = (r_fc == mbr_pkg::FN_WRITE1) ? r_rx_q : r_qty;
        bb      = '0;
        avail   = '0;
        q       = '0;

        case (mbr_pkg::t_cmd'(r_item.cmd))
            mbr_pkg::CMD_RX: begin
                if (!r_pend) begin
                    case (r_phase)
                        mbr_pkg::PH_STATION: begin
                            n_crc = mbr_pkg::CRC_INIT;
                            if (b == r_station) begin
                                n_crc   = mbr_pkg::crc_next(mbr_pkg::CRC_INIT, b);
                                n_phase = mbr_pkg::PH_FUNC;
                            end
                        end
                        mbr_pkg::PH_FUNC: begin
                            if (b inside {mbr_pkg::FN_READ, mbr_pkg::FN_WRITE1,
                                          mbr_pkg::FN_WRITEN}) begin
                                n_crc   = mbr_pkg::crc_next(r_crc, b);
                                n_fc    = b;
                                n_phase = mbr_pkg::PH_ADDR_HI;
                            end else begin
                                n_phase = mbr_pkg::PH_STATION;
                                n_crc   = mbr_pkg::CRC_INIT;
                            end
                        end
                        mbr_pkg::PH_ADDR_HI, mbr_pkg::PH_QTY_HI, mbr_pkg::PH_DATA_HI: begin
                            n_crc   = mbr_pkg::crc_next(r_crc, b);
                            n_hold  = b;
                            n_phase = mbr_pkg::t_phase'(r_phase + 4'd1);
                        end
                        mbr_pkg::PH_ADDR_LO: begin
                            n_crc   = mbr_pkg::crc_next(r_crc, b);
                            n_start = word;
                            n_phase = mbr_pkg::PH_QTY_HI;
                        end
                        mbr_pkg::PH_QTY_LO: begin
                            n_crc = mbr_pkg::crc_next(r_crc, b);
                            if (r_fc == mbr_pkg::FN_WRITE1) begin
                                rx_we = 1'b1;
                                rx_wd = word;
                            end else begin
                                n_qty = word;
                            end
                            n_phase = (r_fc == mbr_pkg::FN_WRITEN) ? mbr_pkg::PH_COUNT
                                                                   : mbr_pkg::PH_CRC_A;
                        end
                        mbr_pkg::PH_COUNT: begin
                            n_crc   = mbr_pkg::crc_next(r_crc, b);
                            n_qty   = {9'h000, b[7:1]};
                            n_wi    = '0;
                            n_phase = (b[7:1] == 7'd0) ? mbr_pkg::PH_CRC_A
                                                       : mbr_pkg::PH_DATA_HI;
                        end
                        mbr_pkg::PH_DATA_LO: begin
                            n_crc   = mbr_pkg::crc_next(r_crc, b);
                            rx_we   = 1'b1;
                            rx_wa   = r_wi[mbr_pkg::RX_AW-1:0];
                            rx_wd   = word;
                            n_wi    = wi_inc[7:0];
                            n_phase = ({7'h00, wi_inc} >= r_qty) ? mbr_pkg::PH_CRC_A
                                                                 : mbr_pkg::PH_DATA_HI;
                        end
                        mbr_pkg::PH_CRC_A: begin
                            if (b == r_crc[7:0]) begin
                                n_phase = mbr_pkg::PH_CRC_B;
                            end else begin
                                n_phase = mbr_pkg::PH_STATION;
                                n_crc   = mbr_pkg::CRC_INIT;
                            end
                        end
                        mbr_pkg::PH_CRC_B: begin
                            n_phase = mbr_pkg::PH_STATION;
                            n_crc   = mbr_pkg::CRC_INIT;
                            if (b == r_crc[15:8]) begin
                                // frame good: clamp read count, make output pending
                                if (r_fc == mbr_pkg::FN_READ) begin
                                    avail = ({1'b0, r_start} < MEM_END) ?
                                            MEM_END - {1'b0, r_start} : 17'd0;
                                    q = (r_qty > mbr_pkg::MAX_READ) ? mbr_pkg::MAX_READ
                                                                    : r_qty;
                                    if ({1'b0, q} > avail) begin
                                        q = avail[15:0];
                                    end
                                    n_qty = q;
                                end
                                n_pend               = 1'b1;
                                n_oidx               = '0;
                                n_out.frame_received = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = mbr_pkg::PH_STATION;
                            n_crc   = mbr_pkg::CRC_INIT;
                        end
                    endcase
                end
            end
            mbr_pkg::CMD_ADV: begin
                if (r_pend) begin
                    n_oidx = r_oidx + 9'd1;
                    if (r_oidx < notes) begin
                        // write notification
                        n_out.write_valid = 1'b1;
                        n_out.write_addr  = r_start + {7'h00, r_oidx};
                        n_out.write_value = r_rx_q;
                    end else begin
                        n_out.tx_valid = 1'b1;
                        if (j_idx < body) begin
                            // response body byte
                            if (j_idx == 9'd0) begin
                                bb = r_station;
                            end else if (j_idx == 9'd1) begin
                                bb = r_fc;
                            end else if (r_fc == mbr_pkg::FN_READ) begin
                                if (j_idx == 9'd2) begin
                                    bb = {r_qty[6:0], 1'b0};
                                end else if (j_idx[0]) begin
                                    bb = mem_val[15:8];
                                end else begin
                                    bb = mem_val[7:0];
                                end
                            end else begin
                                case (j_idx[2:0])
                                    3'd2:    bb = r_start[15:8];
                                    3'd3:    bb = r_start[7:0];
                                    3'd4:    bb = v[15:8];
                                    default: bb = v[7:0];
                                endcase
                            end
                            n_crc         = mbr_pkg::crc_next(r_crc, bb);
                            n_out.tx_byte = bb;
                        end else if (j_idx == body) begin
                            n_out.tx_byte = r_crc[7:0];
                        end else begin
                            n_out.tx_byte = r_crc[15:8];
                            n_out.tx_last = 1'b1;
                            n_pend        = 1'b0;
                            n_oidx        = '0;
                            n_crc         = mbr_pkg::CRC_INIT;
                        end
                    end
                end
            end
            mbr_pkg::CMD_HWR: begin
                if ({1'b0, r_item.host_addr} < MEM_END) begin
                    mem_we = 1'b1;
                    mem_wa = r_item.host_addr[MEM_AW-1:0];
                    mem_wd = r_item.host_value;
                end
            end
            mbr_pkg::CMD_HRD: begin
                n_out.read_value = mem_val;
            end
            default: begin
                n_out = '0;
            end
        endcase

        n_out.transmitting = r_pend || n_pend;

        // state only moves when the item completes
        if (!done) begin
            rx_we  = 1'b0;
            mem_we = 1'b0;
        end
        // clearing pass owns the memory write port
        if (r_clr_busy) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_exec      <= 1'b0;
            r_out_valid <= 1'b0;
            r_station   <= '0;
            r_phase     <= mbr_pkg::PH_STATION;
            r_crc       <= mbr_pkg::CRC_INIT;
            r_fc        <= '0;
            r_start     <= '0;
            r_qty       <= '0;
            r_wi        <= '0;
            r_hold      <= '0;
            r_oidx      <= '0;
            r_pend      <= 1'b0;
        end else begin
            // clearing pass
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == MEM_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            // station id transfer
            if (i_cfg.valid) begin
                r_station <= i_cfg.data;
            end
            // execute slot
            if (accept) begin
                r_exec <= 1'b1;
            end else if (done) begin
                r_exec <= 1'b0;
            end
            // result register
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (done) begin
                r_phase <= n_phase;
                r_crc   <= n_crc;
                r_fc    <= n_fc;
                r_start <= n_start;
                r_qty   <= n_qty;
                r_wi    <= n_wi;
                r_hold  <= n_hold;
                r_oidx  <= n_oidx;
                r_pend  <= n_pend;
            end
        end
    end

    // checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in.ready)
        else $error("item accepted during memory clear");

    a_accept_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_exec)
        else $error("accepted item not in execute slot");

    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exec && r_out_valid && !o_out.ready) |=> (r_exec && $stable(r_item)))
        else $error("stalled item lost");

    a_frame_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && n_out.frame_received) |=> r_pend)
        else $error("good frame without pending output");

endmodule
`default_nettype wire

// ===== bench/modbus_rtu_slave_frame_engine_core_tb.sv =====
// testbench for the modbus rtu slave frame engine: random frames against a scoreboard
`timescale 1ns / 1ps
module modbus_rtu_slave_frame_engine_core_tb;
    import mbr_pkg::*;

    localparam int MEMW       = MEM_WORDS_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int ITEM_GOAL  = 1600;

    // scoreboard: frame engine predictor plus queue of expected results
    class mbr_scoreboard;
        t_out_item   exp_results[$];
        int          errors;
        logic [7:0]  station;
        t_phase      phase;
        logic [15:0] crc;
        logic [7:0]  func;
        logic [15:0] start_addr;
        logic [15:0] qty;
        logic [7:0]  word_idx;
        logic [7:0]  hold;
        logic [15:0] rx_words [RX_WORDS];
        logic [15:0] mem [MEMW];
        logic [8:0]  out_idx;
        bit          pending;

        function new();
            station = 8'h00;
            phase = PH_STATION;
            crc = CRC_INIT;
            func = 8'h00;
            start_addr = 16'h0;
            qty = 16'h0;
            word_idx = 8'h0;
            hold = 8'h0;
            out_idx = 9'h0;
            pending = 1'b0;
            errors = 0;
            foreach (rx_words[i]) rx_words[i] = 16'h0;
            foreach (mem[i]) mem[i] = 16'h0;
        endfunction

        static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
            logic [15:0] v;
            v = c ^ {8'h00, b};
            repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
            return v;
        endfunction

        function logic [15:0] mem_word(int unsigned a);
            return (a < MEMW) ? mem[a] : 16'h0;
        endfunction

        function void hunt();
            phase = PH_STATION;
            crc = CRC_INIT;
        endfunction

        // one line byte through the parser, returns 1 on a frame that passes crc
        function bit parse_byte(logic [7:0] b);
            logic [15:0] v;
            int unsigned avail;
            case (phase)
                PH_STATION: begin
                    crc = CRC_INIT;
                    if (b == station) begin
                        crc = crc_byte(crc, b);
                        phase = PH_FUNC;
                    end
                end
                PH_FUNC: begin
                    if (b == FN_READ || b == FN_WRITE1 || b == FN_WRITEN) begin
                        crc = crc_byte(crc, b);
                        func = b;
                        phase = PH_ADDR_HI;
                    end else begin
                        hunt();
                    end
                end
                PH_ADDR_HI, PH_QTY_HI, PH_DATA_HI: begin
                    crc = crc_byte(crc, b);
                    hold = b;
                    phase = t_phase'(phase + 1);
                end
                PH_ADDR_LO: begin
                    crc = crc_byte(crc, b);
                    start_addr = {hold, b};
                    phase = PH_QTY_HI;
                end
                PH_QTY_LO: begin
                    v = {hold, b};
                    crc = crc_byte(crc, b);
                    if (func == FN_WRITE1) rx_words[0] = v;
                    else qty = v;
                    phase = (func == FN_WRITEN) ? PH_COUNT : PH_CRC_A;
                end
                PH_COUNT: begin
                    crc = crc_byte(crc, b);
                    qty = {9'h0, b[7:1]};
                    word_idx = 8'h0;
                    phase = (qty == 16'h0) ? PH_CRC_A : PH_DATA_HI;
                end
                PH_DATA_LO: begin
                    crc = crc_byte(crc, b);
                    rx_words[word_idx[6:0]] = {hold, b};
                    word_idx = word_idx + 8'd1;
                    phase = ({8'h0, word_idx} >= qty) ? PH_CRC_A : PH_DATA_HI;
                end
                PH_CRC_A: begin
                    if (b == crc[7:0]) phase = PH_CRC_B;
                    else hunt();
                end
                PH_CRC_B: begin
                    if (b != crc[15:8]) begin
                        hunt();
                        return 1'b0;
                    end
                    // frame good: clamp the read count and arm the response
                    if (func == FN_READ) begin
                        avail = (start_addr < MEMW) ? MEMW - start_addr : 0;
                        if (qty > MAX_READ) qty = MAX_READ;
                        if (qty > avail) qty = avail[15:0];
                    end
                    pending = 1'b1;
                    out_idx = 9'h0;
                    hunt();
                    return 1'b1;
                end
                default: hunt();
            endcase
            return 1'b0;
        endfunction

        function logic [7:0] resp_byte(int unsigned j);
            logic [15:0] v;
            if (j == 0) return station;
            if (j == 1) return func;
            if (func == FN_READ) begin
                if (j == 2) return qty[6:0] * 8'd2;
                v = mem_word(start_addr + ((j - 3) >> 1));
                return ((j - 3) % 2) ? v[7:0] : v[15:8];
            end
            v = (func == FN_WRITE1) ? rx_words[0] : qty;
            case (j)
                2: return start_addr[15:8];
                3: return start_addr[7:0];
                4: return v[15:8];
                default: return v[7:0];
            endcase
        endfunction

        // one step of the response sequence: notifications, body, crc
        function void step_output(ref t_out_item r);
            int unsigned notes, body, j;
            notes = (func == FN_WRITE1) ? 1 : (func == FN_READ) ? 0 : qty;
            body  = (func == FN_READ) ? 3 + 2 * qty : 6;
            if (out_idx < notes) begin
                r.write_valid = 1'b1;
                r.write_addr  = start_addr + out_idx;
                r.write_value = rx_words[out_idx[6:0]];
            end else begin
                j = out_idx - notes;
                r.tx_valid = 1'b1;
                if (j < body) begin
                    r.tx_byte = resp_byte(j);
                    crc = crc_byte(crc, r.tx_byte);
                end else if (j == body) begin
                    r.tx_byte = crc[7:0];
                end else begin
                    r.tx_byte = crc[15:8];
                    r.tx_last = 1'b1;
                    pending = 1'b0;
                    out_idx = 9'h0;
                    crc = CRC_INIT;
                    return;
                end
            end
            out_idx = out_idx + 9'd1;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            bit was_pending;
            r = '0;
            was_pending = pending;
            case (t_cmd'(it.cmd))
                CMD_RX:  if (!pending && parse_byte(it.rx_byte)) r.frame_received = 1'b1;
                CMD_ADV: if (pending) step_output(r);
                CMD_HWR: if (it.host_addr < MEMW) mem[it.host_addr] = it.host_value;
                default: r.read_value = mem_word(it.host_addr);
            endcase
            r.transmitting = was_pending || pending;
            exp_results.push_back(r);
        endfunction

        task report(string field, logic [15:0] got, logic [15:0] want);
            errors++;
            $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $time);
        endtask

        task cmp(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want) report(field, got, want);
        endtask

        task check(t_out_item got);
            t_out_item e;
            if (exp_results.size() == 0) begin
                report("unexpected result", 16'h0, 16'h0);
                return;
            end
            e = exp_results.pop_front();
            cmp("tx_valid", got.tx_valid, e.tx_valid);
            cmp("tx_byte", got.tx_byte, e.tx_byte);
            cmp("tx_last", got.tx_last, e.tx_last);
            cmp("write_valid", got.write_valid, e.write_valid);
            cmp("write_addr", got.write_addr, e.write_addr);
            cmp("write_value", got.write_value, e.write_value);
            cmp("read_value", got.read_value, e.read_value);
            cmp("frame_received", got.frame_received, e.frame_received);
            cmp("transmitting", got.transmitting, e.transmitting);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    mbr_in_if  in_ch ();
    mbr_out_if out_ch ();
    mbr_cfg_if cfg_ch ();

    modbus_rtu_slave_frame_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    mbr_scoreboard sb = new();
    int items_sent = 0;
    int burst_left = 0;
    int hold_left  = 0;
    int idle_count = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: own stall pattern plus long hold-off on request
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) sb.check(out_ch.data);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (($time / 2000) % 3 == 0) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task send_item(t_cmd cmd, logic [7:0] rx, logic [15:0] addr, logic [15:0] val);
        t_in_item it;
        int gap;
        it.cmd = cmd;
        it.rx_byte = rx;
        it.host_addr = addr;
        it.host_value = val;
        // bursts with random gaps between them
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(it);
        items_sent++;
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.exp_results.size() != 0) @(posedge i_clk);
    endtask

    task write_station(logic [7:0] id);
        drain();
        repeat (4) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= id;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.station = id;
        cfg_ch.valid <= 1'b0;
    endtask

    // run the response out, with occasional host traffic and busy line bytes
    task flush_response();
        while (sb.pending) begin
            case ($urandom_range(0, 19))
                0: send_item(CMD_RX, 8'($urandom), 16'h0, 16'h0);
                1: send_item(CMD_HWR, 8'h0, 16'($urandom_range(0, MEMW - 1)), 16'($urandom));
                2: send_item(CMD_HRD, 8'h0, 16'($urandom_range(0, MEMW + 3)), 16'h0);
                default: send_item(CMD_ADV, 8'h0, 16'h0, 16'h0);
            endcase
        end
    endtask

    task send_frame(logic [7:0] st, logic [7:0] fn, logic [15:0] addr,
                    logic [15:0] qv, logic [7:0] bcount, bit bad_crc);
        logic [7:0]  frame [$];
        logic [15:0] c;
        int k;
        frame = {st, fn, addr[15:8], addr[7:0], qv[15:8], qv[7:0]};
        if (fn == FN_WRITEN) begin
            frame.push_back(bcount);
            for (k = 0; k < 2 * (bcount >> 1); k++) frame.push_back(8'($urandom));
        end
        c = CRC_INIT;
        foreach (frame[i]) c = mbr_scoreboard::crc_byte(c, frame[i]);
        if (bad_crc) c = c ^ (16'h1 << $urandom_range(0, 15));
        frame.push_back(c[7:0]);
        frame.push_back(c[15:8]);
        foreach (frame[i]) send_item(CMD_RX, frame[i], 16'($urandom), 16'($urandom));
        flush_response();
    endtask

    task random_frame();
        logic [7:0]  fn;
        logic [7:0]  st;
        logic [15:0] addr;
        logic [15:0] qv;
        logic [7:0]  bcount;
        int r;
        r = $urandom_range(0, 9);
        fn = (r < 4) ? FN_READ : (r < 7) ? FN_WRITEN : (r < 9) ? FN_WRITE1 : 8'($urandom);
        st = ($urandom_range(0, 15) == 0) ? 8'($urandom) : sb.station;
        addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
               16'($urandom_range(0, MEMW + 8));
        qv = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        bcount = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
        send_frame(st, fn, addr, qv, bcount, $urandom_range(0, 9) == 0);
    endtask

    task random_host();
        case ($urandom_range(0, 3))
            0: send_item(CMD_HWR, 8'h0, 16'($urandom), 16'($urandom));
            1: send_item(CMD_HWR, 8'h0, 16'($urandom_range(0, MEMW - 1)), 16'($urandom));
            2: send_item(CMD_HRD, 8'h0, 16'($urandom_range(0, MEMW + 3)), 16'h0);
            default: send_item(CMD_RX, 8'($urandom), 16'h0, 16'h0);
        endcase
    endtask

    initial begin
        logic [7:0] settings [5];
        int p;
        int n;
        settings = '{8'h00, 8'hFF, 8'h01, 8'($urandom_range(2, 254)), 8'h00};
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: host memory extremes, idle advance, frames for each function, bad crc, unknown function
        write_station(8'h11);
        send_item(CMD_ADV, 8'h00, 16'h0000, 16'h0000);
        send_item(CMD_HWR, 8'h00, 16'h0000, 16'h8000);
        send_item(CMD_HWR, 8'h00, 16'(MEMW - 1), 16'h7FFF);
        send_item(CMD_HWR, 8'h00, 16'(MEMW), 16'hFFFF);
        send_item(CMD_HWR, 8'h00, 16'hFFFF, 16'h1234);
        send_item(CMD_HRD, 8'h00, 16'h0000, 16'h0000);
        send_item(CMD_HRD, 8'h00, 16'(MEMW - 1), 16'h0000);
        send_item(CMD_HRD, 8'h00, 16'hFFFF, 16'h0000);
        send_frame(8'h11, FN_WRITE1, 16'hFFFF, 16'hA5C3, 8'h0, 1'b0);
        send_frame(8'h11, FN_READ, 16'(MEMW - 2), 16'hFFFF, 8'h0, 1'b0);
        send_frame(8'h11, FN_READ, 16'(MEMW), 16'h0003, 8'h0, 1'b0);
        send_frame(8'h11, FN_WRITEN, 16'hFFFE, 16'h0000, 8'h05, 1'b0);
        send_frame(8'h11, FN_WRITEN, 16'h0010, 16'h0000, 8'h00, 1'b0);
        send_frame(8'h11, FN_READ, 16'h0000, 16'h0002, 8'h0, 1'b1);
        send_frame(8'h11, 8'h03, 16'h0000, 16'h0002, 8'h0, 1'b0);

        // random phases over several station ids
        for (p = 0; p < 5; p++) begin
            write_station(settings[p]);
            n = items_sent + ITEM_GOAL / 5;
            while (items_sent < n) begin
                if ($urandom_range(0, 4) == 0) random_host();
                else random_frame();
                if (p == 1 && items_sent > n - ITEM_GOAL / 10 && hold_left == 0) begin
                    // long receiver hold-off while the sender keeps offering
                    hold_left = 400;
                    repeat (30) random_host();
                end
                if (p == 2 && $urandom_range(0, 30) == 0) drain();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
